// ----- design/slbs_pkg.sv -----
// Shared types, constants and helpers for the byte-stuffing link framer.
// Used by slbs_cfg, slbs_core and spi_link_byte_stuffing_fifos.
// No dependencies.
package slbs_pkg;

  // Ring sizes. TX_DEPTH must be even: the transmit ring is split into
  // two banks on the index LSB so that an escape pair is written at once.
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_BANK_DEPTH = TX_DEPTH / 2;
  localparam int TX_RW = TX_AW - 1;

  // Operation codes
  localparam logic [1:0] OP_HOST_SEND = 2'd0;
  localparam logic [1:0] OP_LINE_RECV = 2'd1;
  localparam logic [1:0] OP_HOST_READ = 2'd2;
  localparam logic [1:0] OP_LINE_TAKE = 2'd3;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_ESCAPE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_IDLE      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_XON       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_XOFF      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_READY     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_DEAD_LOW  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_DEAD_HIGH = 3'd6;

  // Reset values of the codes
  localparam logic [7:0] RST_ESCAPE    = 8'hFB;
  localparam logic [7:0] RST_IDLE      = 8'hF5;
  localparam logic [7:0] RST_XON       = 8'hFA;
  localparam logic [7:0] RST_XOFF      = 8'hFD;
  localparam logic [7:0] RST_READY     = 8'hF3;
  localparam logic [7:0] RST_DEAD_LOW  = 8'h00;
  localparam logic [7:0] RST_DEAD_HIGH = 8'hFF;

  localparam logic [7:0] FLIP_MASK = 8'h20;
  localparam logic [7:0] FILL_F1   = 8'hF1;
  localparam logic [7:0] FILL_F4   = 8'hF4;
  localparam logic [7:0] FILL_F7   = 8'hF7;

  typedef struct packed {
    logic [7:0] escape;
    logic [7:0] idle;
    logic [7:0] xon;
    logic [7:0] xoff;
    logic [7:0] ready;
    logic [7:0] dead_low;
    logic [7:0] dead_high;
  } codes_t;

  typedef struct packed {
    logic accepted;
    logic link_up;
    logic may_send;
    logic slow_start;
    logic rx_has_data;
    logic tx_has_data;
  } result_t;

  function automatic logic [RX_AW-1:0] rx_adv(input logic [RX_AW-1:0] idx);
    rx_adv = (idx == RX_AW'(RX_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [TX_AW-1:0] tx_adv(input logic [TX_AW-1:0] idx);
    tx_adv = (idx == TX_AW'(TX_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

// ----- design/spi_link_byte_stuffing_fifos.sv -----
// Byte-stuffing link framer with transmit and receive ring FIFOs.
// A request accepted at one edge has its result in the result register
// and the ring RAM read register right after that edge.
// Throughput: one request per cycle while the result side does not stall.
// Reset (rst_n low, synchronous): rings empty, link and escape flags cleared,
// send permission and slow start set, codes restored; ring contents undefined.
module spi_link_byte_stuffing_fifos (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [slbs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0]                  cfg_wdata,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [7:0]                  in_data_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic [7:0]                  out_data_out,
  output logic                        out_link_up,
  output logic                        out_may_send,
  output logic                        out_slow_start,
  output logic                        out_rx_has_data,
  output logic                        out_tx_has_data
);

  slbs_pkg::codes_t  codes;
  slbs_pkg::result_t res;
  slbs_pkg::result_t res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic [7:0]        pop_byte;

  // Hold new requests only while a finished result waits and is stalled;
  // when the result is taken this cycle, a new request slips in behind it.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  slbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .codes     (codes)
  );

  // The core advances its state only on an accepted request, so the
  // registered RAM read data and source select hold through a stall.
  slbs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .op       (in_operation),
    .data     (in_data_in),
    .codes    (codes),
    .res      (res),
    .pop_byte (pop_byte)
  );

  // Result register: load on accept, drop when taken, hold when stalled.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = res_r.accepted;
  assign out_data_out    = pop_byte;
  assign out_link_up     = res_r.link_up;
  assign out_may_send    = res_r.may_send;
  assign out_slow_start  = res_r.slow_start;
  assign out_rx_has_data = res_r.rx_has_data;
  assign out_tx_has_data = res_r.tx_has_data;

endmodule

// ----- design/slbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module slbs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/slbs_cfg.sv -----
// Configuration register file: the seven framing codes.
// Depends on slbs_pkg.
module slbs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [slbs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [7:0]                   cfg_wdata,
  output slbs_pkg::codes_t             codes
);

  slbs_pkg::codes_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.escape    <= slbs_pkg::RST_ESCAPE;
      codes_r.idle      <= slbs_pkg::RST_IDLE;
      codes_r.xon       <= slbs_pkg::RST_XON;
      codes_r.xoff      <= slbs_pkg::RST_XOFF;
      codes_r.ready     <= slbs_pkg::RST_READY;
      codes_r.dead_low  <= slbs_pkg::RST_DEAD_LOW;
      codes_r.dead_high <= slbs_pkg::RST_DEAD_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        slbs_pkg::REG_ESCAPE:    codes_r.escape    <= cfg_wdata;
        slbs_pkg::REG_IDLE:      codes_r.idle      <= cfg_wdata;
        slbs_pkg::REG_XON:       codes_r.xon       <= cfg_wdata;
        slbs_pkg::REG_XOFF:      codes_r.xoff      <= cfg_wdata;
        slbs_pkg::REG_READY:     codes_r.ready     <= cfg_wdata;
        slbs_pkg::REG_DEAD_LOW:  codes_r.dead_low  <= cfg_wdata;
        slbs_pkg::REG_DEAD_HIGH: codes_r.dead_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign codes = codes_r;

endmodule

// ----- design/slbs_core.sv -----
// Framer datapath: ring pointers, link flags, escape/decode logic and ring RAMs.
// Depends on slbs_pkg and slbs_ram.
module slbs_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [1:0]           op,
  input  logic [7:0]           data,
  input  slbs_pkg::codes_t     codes,
  output slbs_pkg::result_t    res,
  output logic [7:0]           pop_byte
);

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_RX   = 2'd1;
  localparam logic [1:0] SRC_TX0  = 2'd2;
  localparam logic [1:0] SRC_TX1  = 2'd3;

  localparam int RA = slbs_pkg::RX_AW;
  localparam int TA = slbs_pkg::TX_AW;
  localparam int TR = slbs_pkg::TX_RW;

  logic [RA-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [TA-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic          esc_r, esc_nxt, link_r, link_nxt, allow_r, allow_nxt;
  logic          slow_r, slow_nxt;
  logic [1:0]    src_r, src_nxt;

  logic [TA-1:0] tx_first, tx_second;
  logic          special, store, ok;
  logic [7:0]    store_byte;
  logic          rx_we, tx_single, tx_pair, pop_rx, pop_tx;
  logic          bank_we [2];
  logic [TR-1:0] bank_waddr [2];
  logic [7:0]    bank_wdata [2];
  logic [7:0]    bank_rdata [2];
  logic [7:0]    rx_rdata;

  assign tx_first  = slbs_pkg::tx_adv(tx_head_r);
  assign tx_second = slbs_pkg::tx_adv(tx_first);

  assign special = (data == codes.idle) || (data == codes.escape) ||
                   (data == codes.xon) || (data == codes.xoff) ||
                   (data == codes.dead_low) || (data == codes.dead_high) ||
                   (data == codes.ready);

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    esc_nxt     = esc_r;
    link_nxt    = link_r;
    allow_nxt   = allow_r;
    slow_nxt    = slow_r;
    store       = 1'b0;
    store_byte  = data;
    ok          = 1'b0;
    rx_we       = 1'b0;
    tx_single   = 1'b0;
    tx_pair     = 1'b0;
    pop_rx      = 1'b0;
    pop_tx      = 1'b0;
    case (op)
      slbs_pkg::OP_HOST_SEND: begin
        if (special) begin
          if (tx_first != tx_tail_r && tx_second != tx_tail_r) begin
            tx_pair     = 1'b1;
            tx_head_nxt = tx_second;
            ok          = 1'b1;
          end
        end else if (tx_first != tx_tail_r) begin
          tx_single   = 1'b1;
          tx_head_nxt = tx_first;
          ok          = 1'b1;
        end
      end
      slbs_pkg::OP_LINE_RECV: begin
        if (esc_r) begin
          esc_nxt    = 1'b0;
          store      = 1'b1;
          store_byte = data ^ slbs_pkg::FLIP_MASK;
        end else if (data == codes.dead_low || data == codes.dead_high) begin
          link_nxt = 1'b0;
        end else begin
          link_nxt = 1'b1;
          if (data == codes.escape) begin
            esc_nxt = 1'b1;
          end else if (data == codes.idle || data == slbs_pkg::FILL_F1 ||
                       data == slbs_pkg::FILL_F4 || data == slbs_pkg::FILL_F7) begin
            // drop filler
          end else if (data == codes.xon) begin
            allow_nxt = 1'b1;
          end else if (data == codes.xoff) begin
            allow_nxt = 1'b0;
          end else begin
            store = 1'b1;
          end
        end
        if (store) begin
          slow_nxt = 1'b0;
          if (slbs_pkg::rx_adv(rx_head_r) != rx_tail_r) begin
            rx_we       = 1'b1;
            rx_head_nxt = slbs_pkg::rx_adv(rx_head_r);
            ok          = 1'b1;
          end
        end
      end
      slbs_pkg::OP_HOST_READ: begin
        if (rx_head_r != rx_tail_r) begin
          pop_rx      = 1'b1;
          rx_tail_nxt = slbs_pkg::rx_adv(rx_tail_r);
          ok          = 1'b1;
        end
      end
      slbs_pkg::OP_LINE_TAKE: begin
        if (allow_r && tx_head_r != tx_tail_r) begin
          pop_tx      = 1'b1;
          tx_tail_nxt = slbs_pkg::tx_adv(tx_tail_r);
          ok          = 1'b1;
        end
      end
      default: ;
    endcase

    if (pop_rx) begin
      src_nxt = SRC_RX;
    end else if (pop_tx) begin
      src_nxt = tx_tail_r[0] ? SRC_TX1 : SRC_TX0;
    end else begin
      src_nxt = SRC_NONE;
    end
  end

  // Bank b holds even (b=0) or odd (b=1) transmit slots; an escape pair
  // always spans both banks.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (tx_head_r[0] == b[0]) begin
        bank_we[b]    = step && (tx_single || tx_pair);
        bank_waddr[b] = tx_head_r[TA-1:1];
        bank_wdata[b] = tx_pair ? codes.escape : data;
      end else begin
        bank_we[b]    = step && tx_pair;
        bank_waddr[b] = tx_first[TA-1:1];
        bank_wdata[b] = data ^ slbs_pkg::FLIP_MASK;
      end
    end
  end

  slbs_ram #(.DEPTH(slbs_pkg::RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (step && rx_we),
    .waddr (rx_head_r),
    .wdata (store_byte),
    .re    (step && pop_rx),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  for (genvar g = 0; g < 2; g++) begin : g_tx_bank
    slbs_ram #(.DEPTH(slbs_pkg::TX_BANK_DEPTH), .WIDTH(8)) u_tx_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .re    (step && pop_tx && (tx_tail_r[0] == 1'(g))),
      .raddr (tx_tail_r[TA-1:1]),
      .rdata (bank_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
      esc_r     <= 1'b0;
      link_r    <= 1'b0;
      allow_r   <= 1'b1;
      slow_r    <= 1'b1;
      src_r     <= SRC_NONE;
    end else if (step) begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      esc_r     <= esc_nxt;
      link_r    <= link_nxt;
      allow_r   <= allow_nxt;
      slow_r    <= slow_nxt;
      src_r     <= src_nxt;
    end
  end

  always_comb begin
    case (src_r)
      SRC_RX:  pop_byte = rx_rdata;
      SRC_TX0: pop_byte = bank_rdata[0];
      SRC_TX1: pop_byte = bank_rdata[1];
      default: pop_byte = 8'h00;
    endcase
  end

  assign res.accepted    = ok;
  assign res.link_up     = link_nxt;
  assign res.may_send    = allow_nxt;
  assign res.slow_start  = slow_nxt;
  assign res.rx_has_data = (rx_head_nxt != rx_tail_nxt);
  assign res.tx_has_data = (tx_head_nxt != tx_tail_nxt);

endmodule
